### src/wmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmt_pkg
// Shared widths, status codes, queue word type and saturation helpers for the
// weighted three-axis moment accumulator.
// ----------------------------------------------------------------------------
package wmt_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 16;
    localparam int WT_W     = 32;
    localparam int FM_W     = 48;
    localparam int SM_W     = 64;
    localparam int VW_W     = 32;
    localparam int MEAN_W   = 16;
    localparam int VAR_W    = 32;
    localparam int DIV_W    = 64;
    localparam int DSR_W    = 33;
    localparam int STEP_W   = 6;
    localparam int AXES     = 3;
    localparam int AXIS_W   = 2;
    localparam int PARTS_W  = 2;

    localparam logic [WEIGHT_W-1:0] DOF_RESET   = 16'd256;
    localparam logic [PARTS_W-1:0]  PARTS_NONE  = 2'd0;
    localparam logic [PARTS_W-1:0]  PARTS_MEANS = 2'd1;
    localparam logic [PARTS_W-1:0]  PARTS_ALL   = 2'd2;

    typedef struct packed {
        logic [WT_W-1:0]            wt;
        logic [AXES-1:0][FM_W-1:0]  fm;
        logic [AXES-1:0][SM_W-1:0]  sm;
    } moments_t;

    function automatic logic [MEAN_W-1:0] sat16(input logic [DIV_W-1:0] mag,
                                                 input logic neg);
        logic [MEAN_W-1:0] r;
        logic [DIV_W-1:0]  ng;
        begin
            ng = -mag;
            if (neg)
                r = (mag > 64'd32768) ? 16'h8000 : ng[MEAN_W-1:0];
            else
                r = (mag > 64'd32767) ? 16'h7fff : mag[MEAN_W-1:0];
            return r;
        end
    endfunction

    function automatic logic [VAR_W-1:0] sat32(input logic [DIV_W-1:0] mag,
                                                input logic neg);
        logic [VAR_W-1:0] r;
        logic [DIV_W-1:0] ng;
        begin
            ng = -mag;
            if (neg)
                r = (mag > 64'd2147483648) ? 32'h8000_0000 : ng[VAR_W-1:0];
            else
                r = (mag > 64'd2147483647) ? 32'h7fff_ffff : mag[VAR_W-1:0];
            return r;
        end
    endfunction

endpackage

### src/weighted_moments_three_axis_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_moments_three_axis_top
// Weighted mean and variance per axis over blocks of Q8.8 samples.
// Throughput: one sample word per cycle while in_stall is low; a last word
//   also costs the back end up to six 64-step divisions on the shared
//   divider before its result word; two finished blocks can queue before
//   the input stalls. A last word passes multiply stages s1 and s2 and is
//   then pushed into the queue; its result word follows the divisions.
// Reset: asynchronous active low; clears sums, queue and sequencer, dof = 1.0.
// ----------------------------------------------------------------------------
module weighted_moments_three_axis_top
    import wmt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SAMPLE_W-1:0] sample_x,
    input  logic [SAMPLE_W-1:0] sample_y,
    input  logic [SAMPLE_W-1:0] sample_z,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic                last,
    input  logic                in_valid,
    output logic                in_stall,
    output logic [MEAN_W-1:0]   mean_x,
    output logic [MEAN_W-1:0]   mean_y,
    output logic [MEAN_W-1:0]   mean_z,
    output logic [VAR_W-1:0]    var_x,
    output logic [VAR_W-1:0]    var_y,
    output logic [VAR_W-1:0]    var_z,
    output logic [PARTS_W-1:0]  valid_parts,
    output logic                out_valid,
    input  logic                out_stall,
    input  logic [WEIGHT_W-1:0] cfg_data,
    input  logic                cfg_valid,
    output logic                cfg_ready
);

    logic [WEIGHT_W-1:0] dof_reg;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    moments_t            q_in;
    moments_t            q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dof_reg <= DOF_RESET;
        else if (cfg_valid && cfg_ready)
            dof_reg <= cfg_data;
    end

    wmt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample_x (sample_x),
        .sample_y (sample_y),
        .sample_z (sample_z),
        .weight   (weight),
        .last     (last),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    wmt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    wmt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .dof         (dof_reg),
        .q_head      (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .mean_x      (mean_x),
        .mean_y      (mean_y),
        .mean_z      (mean_z),
        .var_x       (var_x),
        .var_y       (var_y),
        .var_z       (var_z),
        .valid_parts (valid_parts),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_parts == PARTS_NONE) |->
            (mean_x == '0 && mean_y == '0 && mean_z == '0 && var_x == '0))
        else $error("empty block with non-zero result");

    a_means_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_parts == PARTS_MEANS) |->
            (var_x == '0 && var_y == '0 && var_z == '0))
        else $error("means-only result with non-zero variance");

endmodule

### src/wmt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmt_front
// Two multiply stages and the moment accumulators; a last word pushes the
// finished sums into the queue and clears them.
// ----------------------------------------------------------------------------
module wmt_front
    import wmt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SAMPLE_W-1:0] sample_x,
    input  logic [SAMPLE_W-1:0] sample_y,
    input  logic [SAMPLE_W-1:0] sample_z,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic                last,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                q_full,
    output logic                q_push,
    output moments_t            q_data
);

    logic                             adv;
    logic [AXES-1:0][SAMPLE_W-1:0]    smp;
    logic                             s1_valid_reg;
    logic                             s1_last_reg;
    logic [WEIGHT_W-1:0]              s1_w_reg;
    logic [AXES-1:0][SAMPLE_W-1:0]    s1_v_reg;
    logic [AXES-1:0][VW_W-1:0]        s1_vw_reg;
    logic                             s2_valid_reg;
    logic                             s2_last_reg;
    logic [WEIGHT_W-1:0]              s2_w_reg;
    logic [AXES-1:0][VW_W-1:0]        s2_vw_reg;
    logic [AXES-1:0][FM_W-1:0]        s2_sq_reg;
    moments_t                         acc_reg;
    moments_t                         acc_next;

    assign smp      = {sample_z, sample_y, sample_x};
    assign adv      = !(s2_valid_reg && s2_last_reg && q_full);
    assign in_stall = !adv;

    always_comb
    begin
        acc_next.wt = acc_reg.wt + {16'd0, s2_w_reg};
        for (int i = 0; i < AXES; i++)
        begin
            acc_next.fm[i] = acc_reg.fm[i] + {{16{s2_vw_reg[i][VW_W-1]}}, s2_vw_reg[i]};
            acc_next.sm[i] = acc_reg.sm[i] + {{16{s2_sq_reg[i][FM_W-1]}}, s2_sq_reg[i]};
        end
    end

    assign q_push = adv && s2_valid_reg && s2_last_reg;
    assign q_data = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
                acc_reg <= s2_last_reg ? '0 : acc_next;
        end
    end

    // multiply stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_last_reg <= last;
            s1_w_reg    <= weight;
            for (int i = 0; i < AXES; i++)
            begin
                logic signed [VW_W:0] p1;
                p1 = $signed(smp[i]) * $signed({1'b0, weight});
                s1_v_reg[i]  <= smp[i];
                s1_vw_reg[i] <= p1[VW_W-1:0];
            end
            s2_last_reg <= s1_last_reg;
            s2_w_reg    <= s1_w_reg;
            for (int i = 0; i < AXES; i++)
            begin
                logic signed [FM_W-1:0] p2;
                p2 = $signed(s1_vw_reg[i]) * $signed(s1_v_reg[i]);
                s2_vw_reg[i] <= s1_vw_reg[i];
                s2_sq_reg[i] <= p2;
            end
        end
    end

endmodule

### src/wmt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmt_queue
// Two-entry queue of finished sum sets between accumulator and divider.
// ----------------------------------------------------------------------------
module wmt_queue
    import wmt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  moments_t push_data,
    input  logic     pop,
    output moments_t head,
    output logic     full,
    output logic     empty
);

    moments_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### src/wmt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmt_back
// Sequencer with one shared radix-2 divider: three means, then three variances
// if weight total != dof, then the result word; zero total weight skips all.
// ----------------------------------------------------------------------------
module wmt_back
    import wmt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [WEIGHT_W-1:0]  dof,
    input  moments_t             q_head,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic [MEAN_W-1:0]    mean_x,
    output logic [MEAN_W-1:0]    mean_y,
    output logic [MEAN_W-1:0]    mean_z,
    output logic [VAR_W-1:0]     var_x,
    output logic [VAR_W-1:0]     var_y,
    output logic [VAR_W-1:0]     var_z,
    output logic [PARTS_W-1:0]   valid_parts,
    output logic                 out_valid,
    input  logic                 out_stall
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MEAN = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_VAR  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DEND = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0]                     state_reg;
    logic [AXIS_W-1:0]              axis_reg;
    logic                           phase_var_reg;
    moments_t                       ent_reg;
    logic [AXES-1:0][MEAN_W-1:0]    mean_reg;
    logic [AXES-1:0][VAR_W-1:0]     var_reg;
    logic [PARTS_W-1:0]             parts_reg;
    logic [SM_W-1:0]                prod_reg;
    logic [DIV_W-1:0]               dvd_reg;
    logic [DSR_W-1:0]               dsr_reg;
    logic [DSR_W-1:0]               rem_reg;
    logic [DIV_W-1:0]               quo_reg;
    logic                           neg_reg;
    logic [STEP_W-1:0]              step_reg;
    logic                           out_valid_reg;
    logic [AXES-1:0][MEAN_W-1:0]    out_mean_reg;
    logic [AXES-1:0][VAR_W-1:0]     out_var_reg;
    logic [PARTS_W-1:0]             out_parts_reg;

    logic [FM_W-1:0]                fm_sel;
    logic [SM_W-1:0]                fm_ext;
    logic [SM_W-1:0]                num;
    logic [DSR_W:0]                 den;
    logic [DSR_W:0]                 trial;
    logic signed [SM_W-1:0]         prod;
    logic                           out_free;

    assign fm_sel   = ent_reg.fm[axis_reg];
    assign fm_ext   = {{16{fm_sel[FM_W-1]}}, fm_sel};
    assign num      = ent_reg.sm[axis_reg] - prod_reg;
    assign den      = {2'b00, ent_reg.wt} - {18'd0, dof};
    assign trial    = {rem_reg, dvd_reg[DIV_W-1]} - {1'b0, dsr_reg};
    assign prod     = $signed(fm_sel) * $signed(mean_reg[axis_reg]);
    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg) inside
                ST_IDLE:
                begin
                    if (!q_empty)
                        state_reg <= (q_head.wt == '0) ? ST_FIN : ST_MEAN;
                end
                ST_MEAN, ST_VAR:
                    state_reg <= ST_DIV;
                ST_MUL:
                    state_reg <= ST_VAR;
                ST_DIV:
                begin
                    if (step_reg == '1)
                        state_reg <= ST_DEND;
                end
                ST_DEND:
                begin
                    if (axis_reg != AXIS_W'(AXES - 1))
                        state_reg <= phase_var_reg ? ST_MUL : ST_MEAN;
                    else if (phase_var_reg || ent_reg.wt == {16'd0, dof})
                        state_reg <= ST_FIN;
                    else
                        state_reg <= ST_MUL;
                end
                ST_FIN:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                ent_reg       <= q_head;
                mean_reg      <= '0;
                var_reg       <= '0;
                axis_reg      <= '0;
                phase_var_reg <= 1'b0;
                parts_reg     <= PARTS_NONE;
            end
            ST_MEAN:
            begin
                neg_reg  <= fm_sel[FM_W-1];
                dvd_reg  <= fm_sel[FM_W-1] ? -fm_ext : fm_ext;
                dsr_reg  <= {1'b0, ent_reg.wt};
                rem_reg  <= '0;
                quo_reg  <= '0;
                step_reg <= '0;
            end
            ST_MUL:
                prod_reg <= prod;
            ST_VAR:
            begin
                neg_reg  <= num[SM_W-1] ^ den[DSR_W];
                dvd_reg  <= num[SM_W-1] ? -num : num;
                dsr_reg  <= den[DSR_W] ? (~den[DSR_W-1:0] + 1'b1) : den[DSR_W-1:0];
                rem_reg  <= '0;
                quo_reg  <= '0;
                step_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg  <= trial[DSR_W] ? {rem_reg[DSR_W-2:0], dvd_reg[DIV_W-1]}
                                         : trial[DSR_W-1:0];
                quo_reg  <= {quo_reg[DIV_W-2:0], !trial[DSR_W]};
                dvd_reg  <= {dvd_reg[DIV_W-2:0], 1'b0};
                step_reg <= step_reg + 1'b1;
            end
            ST_DEND:
            begin
                if (phase_var_reg)
                    var_reg[axis_reg] <= sat32(quo_reg, neg_reg);
                else
                    mean_reg[axis_reg] <= sat16(quo_reg, neg_reg);
                if (axis_reg != AXIS_W'(AXES - 1))
                    axis_reg <= axis_reg + 1'b1;
                else if (!phase_var_reg)
                begin
                    axis_reg      <= '0;
                    phase_var_reg <= 1'b1;
                    parts_reg     <= (ent_reg.wt == {16'd0, dof}) ? PARTS_MEANS : PARTS_ALL;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_mean_reg  <= mean_reg;
                    out_var_reg   <= var_reg;
                    out_parts_reg <= parts_reg;
                end
            end
            default:
                ;
        endcase
    end

    assign mean_x      = out_mean_reg[0];
    assign mean_y      = out_mean_reg[1];
    assign mean_z      = out_mean_reg[2];
    assign var_x       = out_var_reg[0];
    assign var_y       = out_var_reg[1];
    assign var_z       = out_var_reg[2];
    assign valid_parts = out_parts_reg;
    assign out_valid   = out_valid_reg;

endmodule

### verif/weighted_moments_three_axis_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_moments_three_axis_top_tb
// Self-checking bench for the weighted three-axis moment accumulator. A
// directed table covers the empty block, weight total equal to and one below
// the dof correction, weight below dof and full-scale samples. Random blocks
// follow under several dof settings, a long output hold-off and random
// idling on both channels. Every result word is checked field by field
// against a behavioural moment predictor or fixed values from the table.
// ----------------------------------------------------------------------------
module weighted_moments_three_axis_top_tb;
    import wmt_pkg::*;

    typedef struct {
        logic [MEAN_W-1:0] mean [AXES];
        logic [VAR_W-1:0]  var_v [AXES];
        logic [PARTS_W-1:0] parts;
    } stats_t;

    typedef struct {
        logic [SAMPLE_W-1:0] x, y, z;
        logic [WEIGHT_W-1:0] w;
        bit                  lst;
        bit                  typed;
        logic [MEAN_W-1:0]   em_x, em_y, em_z;
        logic [PARTS_W-1:0]  eparts;
    } row_t;

    localparam int DIRECTED = 12;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic [SAMPLE_W-1:0] sample_x = '0, sample_y = '0, sample_z = '0;
    logic [WEIGHT_W-1:0] weight = '0;
    logic                last = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [MEAN_W-1:0]   mean_x, mean_y, mean_z;
    logic [VAR_W-1:0]    var_x, var_y, var_z;
    logic [PARTS_W-1:0]  valid_parts;
    logic                out_valid;
    logic                out_stall = 1'b1;
    logic [WEIGHT_W-1:0] cfg_data = '0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;

    // predictor state
    logic [WT_W-1:0]     wt_acc;
    logic [FM_W-1:0]     fm_acc [AXES];
    logic [SM_W-1:0]     sm_acc [AXES];
    logic [WEIGHT_W-1:0] dof;

    stats_t pending_stats [$];
    int     errors = 0;
    int     items = 0;
    bit     send_quiet = 0;
    bit     recv_quiet = 0;
    bit     hold_req = 0;
    int     hold_cnt = 0;
    row_t   plan [DIRECTED];

    weighted_moments_three_axis_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .sample_x(sample_x), .sample_y(sample_y), .sample_z(sample_z),
        .weight(weight), .last(last), .in_valid(in_valid), .in_stall(in_stall),
        .mean_x(mean_x), .mean_y(mean_y), .mean_z(mean_z),
        .var_x(var_x), .var_y(var_y), .var_z(var_z),
        .valid_parts(valid_parts), .out_valid(out_valid), .out_stall(out_stall),
        .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
    );

    always #5 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("[weighted_moments_three_axis_top] ERROR");
        $finish;
    end

    function automatic void clear_moments();
        wt_acc = '0;
        for (int i = 0; i < AXES; i++)
        begin
            fm_acc[i] = '0;
            sm_acc[i] = '0;
        end
    endfunction

    function automatic bit accumulate_moments(input logic [SAMPLE_W-1:0] s [AXES],
                                              input logic [WEIGHT_W-1:0] w,
                                              input bit lst, output stats_t r);
        longint wl, v, vw, fm_s, m, prod, num, den, q;
        wl = longint'(w);
        wt_acc = wt_acc + {16'd0, w};
        for (int i = 0; i < AXES; i++)
        begin
            v = longint'($signed(s[i]));
            vw = v * wl;
            fm_acc[i] = fm_acc[i] + vw[FM_W-1:0];
            sm_acc[i] = sm_acc[i] + vw * v;
        end
        if (!lst)
            return 0;
        r.parts = PARTS_NONE;
        for (int i = 0; i < AXES; i++)
        begin
            r.mean[i] = '0;
            r.var_v[i] = '0;
        end
        if (wt_acc != 0)
        begin
            r.parts = PARTS_MEANS;
            den = longint'(wt_acc) - longint'(dof);
            if (den != 0)
                r.parts = PARTS_ALL;
            for (int i = 0; i < AXES; i++)
            begin
                fm_s = longint'($signed(fm_acc[i]));
                m = fm_s / longint'(wt_acc);
                if (m > 32767) m = 32767;
                if (m < -32768) m = -32768;
                r.mean[i] = m[MEAN_W-1:0];
                if (den != 0)
                begin
                    prod = fm_s * m;
                    num = sm_acc[i] - prod;
                    if (den == -1)
                        q = (num == 64'sh8000_0000_0000_0000) ? 64'sh7fff_ffff_ffff_ffff : -num;
                    else
                        q = num / den;
                    if (q > 64'sd2147483647) q = 64'sd2147483647;
                    if (q < -64'sd2147483648) q = -64'sd2147483648;
                    r.var_v[i] = q[VAR_W-1:0];
                end
            end
        end
        clear_moments();
        return 1;
    endfunction

    task automatic send_word(input logic [SAMPLE_W-1:0] x, y, z,
                             input logic [WEIGHT_W-1:0] w, input bit lst,
                             input bit typed, input stats_t fixed);
        logic [SAMPLE_W-1:0] s [AXES];
        stats_t r;
        while (!send_quiet && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_x <= x;
        sample_y <= y;
        sample_z <= z;
        weight <= w;
        last <= lst;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        s[0] = x;
        s[1] = y;
        s[2] = z;
        items++;
        if (accumulate_moments(s, w, lst, r))
            pending_stats.push_back(typed ? fixed : r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_stats.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_dof(input logic [WEIGHT_W-1:0] d);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        dof = d;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(6))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'($urandom_range(512));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_block();
        int n;
        stats_t none;
        if ($urandom_range(9) == 0)
        begin
            // single sample landing on or just below the dof correction
            if (dof != 0 && $urandom_range(1))
                send_word(pick_sample(), pick_sample(), pick_sample(), dof - 1'b1, 1, 0, none);
            else
                send_word(pick_sample(), pick_sample(), pick_sample(), dof, 1, 0, none);
            return;
        end
        n = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
        for (int k = 0; k < n; k++)
            send_word(pick_sample(), pick_sample(), pick_sample(), pick_weight(),
                      k == n - 1, 0, none);
    endtask

    // result checking and output stall
    always @(posedge clk)
    begin
        stats_t e;
        if (out_valid && !out_stall)
        begin
            if (pending_stats.size() == 0)
            begin
                $display("%0t: unexpected result word parts %0d", $time, valid_parts);
                errors++;
            end
            else
            begin
                e = pending_stats.pop_front();
                if (mean_x !== e.mean[0])
                begin
                    $display("%0t: mean_x exp %h got %h", $time, e.mean[0], mean_x);
                    errors++;
                end
                if (mean_y !== e.mean[1])
                begin
                    $display("%0t: mean_y exp %h got %h", $time, e.mean[1], mean_y);
                    errors++;
                end
                if (mean_z !== e.mean[2])
                begin
                    $display("%0t: mean_z exp %h got %h", $time, e.mean[2], mean_z);
                    errors++;
                end
                if (var_x !== e.var_v[0])
                begin
                    $display("%0t: var_x exp %h got %h", $time, e.var_v[0], var_x);
                    errors++;
                end
                if (var_y !== e.var_v[1])
                begin
                    $display("%0t: var_y exp %h got %h", $time, e.var_v[1], var_y);
                    errors++;
                end
                if (var_z !== e.var_v[2])
                begin
                    $display("%0t: var_z exp %h got %h", $time, e.var_v[2], var_z);
                    errors++;
                end
                if (valid_parts !== e.parts)
                begin
                    $display("%0t: valid_parts exp %0d got %0d", $time, e.parts, valid_parts);
                    errors++;
                end
            end
        end
        if (hold_req && hold_cnt == 0)
        begin
            hold_cnt = 3000;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !recv_quiet && ($urandom_range(99) < 32);
    end

    initial
    begin
        stats_t fixed;
        stats_t none;
        int wait_cnt;

        // x, y, z, weight, last, typed, mean x, y, z, parts
        plan[0]  = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, 0, 0, 0, PARTS_NONE};
        plan[1]  = '{16'h7fff, 16'h8000, 16'h0000, 16'h0100, 1, 1,
                     16'h7fff, 16'h8000, 16'h0000, PARTS_MEANS};
        plan[2]  = '{16'h8000, 16'h7fff, 16'h1234, 16'h00ff, 1, 0, 0, 0, 0, PARTS_NONE};
        plan[3]  = '{16'h8000, 16'h8000, 16'h8000, 16'hffff, 0, 0, 0, 0, 0, PARTS_NONE};
        plan[4]  = '{16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 0, 0, 0, 0, 0, PARTS_NONE};
        plan[5]  = '{16'h8000, 16'h0000, 16'h7fff, 16'hffff, 1, 0, 0, 0, 0, PARTS_NONE};
        plan[6]  = '{16'h0100, 16'hff00, 16'h0080, 16'h0001, 1, 0, 0, 0, 0, PARTS_NONE};
        plan[7]  = '{16'h0300, 16'h0200, 16'hfe00, 16'h0000, 0, 0, 0, 0, 0, PARTS_NONE};
        plan[8]  = '{16'h0100, 16'h0400, 16'h0000, 16'h0200, 0, 0, 0, 0, 0, PARTS_NONE};
        plan[9]  = '{16'hff00, 16'h0100, 16'h5555, 16'h0300, 1, 0, 0, 0, 0, PARTS_NONE};
        plan[10] = '{16'h7fff, 16'h8000, 16'haaaa, 16'h0000, 1, 1, 0, 0, 0, PARTS_NONE};
        plan[11] = '{16'h8000, 16'h7fff, 16'h0001, 16'h8000, 1, 0, 0, 0, 0, PARTS_NONE};

        dof = DOF_RESET;
        clear_moments();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int i = 0; i < DIRECTED; i++)
        begin
            fixed.mean[0] = plan[i].em_x;
            fixed.mean[1] = plan[i].em_y;
            fixed.mean[2] = plan[i].em_z;
            for (int a = 0; a < AXES; a++)
                fixed.var_v[a] = '0;
            fixed.parts = plan[i].eparts;
            send_word(plan[i].x, plan[i].y, plan[i].z, plan[i].w, plan[i].lst,
                      plan[i].typed, fixed);
        end

        write_dof(16'd0);
        send_word(16'h0100, 16'h0100, 16'h0100, 16'h0000, 1, 0, none);
        send_word(16'h8000, 16'h7fff, 16'h0000, 16'h0001, 1, 0, none);
        write_dof(16'hffff);
        send_word(16'h8000, 16'h7fff, 16'h0042, 16'hffff, 1, 0, none);
        send_word(16'h8000, 16'h7fff, 16'h0042, 16'hfffe, 1, 0, none);
        items = 0;

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_dof(16'd0);
                1: write_dof(16'hffff);
                2: write_dof(16'($urandom));
                3: write_dof(16'd1);
                default: write_dof(DOF_RESET);
            endcase
            while (items < (phase + 1) * 230)
            begin
                if (phase == 2 && items > 480 && items < 560)
                begin
                    send_quiet = 1;
                    recv_quiet = 1;
                end
                else
                begin
                    send_quiet = 0;
                    recv_quiet = 0;
                end
                random_block();
            end
            if (phase == 1)
            begin
                // long output hold-off while the sender keeps pushing last words
                hold_req = 1;
                send_quiet = 1;
                for (int k = 0; k < 12; k++)
                    send_word(pick_sample(), pick_sample(), pick_sample(), pick_weight(),
                              1, 0, none);
                hold_req = 0;
                send_quiet = 0;
            end
        end

        in_valid <= 1'b0;
        wait_cnt = 0;
        while (pending_stats.size() != 0 && wait_cnt < 200000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (600) @(posedge clk);
        if (errors == 0 && pending_stats.size() == 0)
            $display("[weighted_moments_three_axis_top] OK");
        else
            $display("[weighted_moments_three_axis_top] ERROR");
        $finish;
    end

endmodule

### filelist.f
src/wmt_pkg.sv
src/wmt_front.sv
src/wmt_queue.sv
src/wmt_back.sv
src/weighted_moments_three_axis_top.sv
verif/weighted_moments_three_axis_top_tb.sv
